/* hw/rtl/bbt_pkg.sv */
`default_nettype none

package bbt_pkg;

    // Item payloads.
    typedef struct packed {
        logic [15:0] kelvin;
    } bbt_kelvin_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } bbt_rgb_t;

    // Knee decisions taken once from the clamped temperature.
    typedef struct packed {
        logic red_hi;
        logic blue_full;
        logic blue_zero;
    } bbt_flags_t;

    localparam logic [15:0] KELVIN_MIN  = 16'd1000;
    localparam logic [15:0] KELVIN_MAX  = 16'd40000;
    localparam logic [15:0] KELVIN_KNEE = 16'd6600;
    localparam logic [15:0] KELVIN_BLUE = 16'd1900;

    // t = floor((k * 65536 + 50) / 100) through a reciprocal of 2^38 / 100.
    localparam logic [63:0] RECIP_100 = ((64'd1 << 38) + 64'd99) / 64'd100;
    localparam logic [24:0] T_OFS_60  = 25'd3932160;
    localparam logic [24:0] T_OFS_10  = 25'd655360;

    localparam logic [63:0] HALF_Q30 = 64'd1 << 29;

    localparam logic [63:0] LN2_Q30 =
        ((64'd6931471806 << 30) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] RECIP_LN2 = (64'd1 << 60) / LN2_Q30;

    localparam logic [63:0] AR_Q16 =
        ((64'd329698727446 << 16) + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] ER_Q30 =
        ((64'd1332047592 << 30) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] AG1_Q16 =
        ((64'd994708025861 << 16) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] BG1_Q16 =
        ((64'd1611195681661 << 16) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] AG2_Q16 =
        ((64'd2881221695283 << 16) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] EG_Q30 =
        ((64'd755148492 << 30) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] AB_Q16 =
        ((64'd1385177312231 << 16) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] BB_Q16 =
        ((64'd3050447927307 << 16) + 64'd5000000000) / 64'd10000000000;

    localparam logic signed [27:0] FULL_SCALE = 28'sd16711680;

    function automatic longint unsigned bbt_isqrt(longint unsigned v);
        longint unsigned rem;
        longint unsigned r;
        longint unsigned b;
        rem = v;
        r   = 64'd0;
        b   = 64'd1 << 62;
        while (b > rem)
        begin
            b = b >> 2;
        end
        while (b != 64'd0)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // One table entry at Q30 position q: log2(1+q) or 2^q, both in Q30.
    function automatic logic [31:0] bbt_tab_entry(longint unsigned q, bit is_exp);
        longint unsigned root [0:30];
        longint unsigned y;
        longint unsigned res;
        longint unsigned r;
        root[0] = 64'd1 << 31;
        for (int k = 1; k <= 30; k++)
        begin
            root[k] = bbt_isqrt(root[k-1] << 30);
        end
        y   = (64'd1 << 30) + q;
        res = 64'd0;
        r   = 64'd1 << 30;
        for (int b = 1; b <= 30; b++)
        begin
            y = (y * y + HALF_Q30) >> 30;
            if (y >= (64'd1 << 31))
            begin
                y   = y >> 1;
                res = res | (64'd1 << (30 - b));
            end
            if (q[30-b])
            begin
                r = (r * root[b] + HALF_Q30) >> 30;
            end
        end
        return is_exp ? 32'(r) : 32'(res);
    endfunction

    // Saturate a signed Q16 channel value to 0..255 with round half up.
    function automatic logic [7:0] bbt_to_byte(logic signed [27:0] v);
        logic signed [27:0] s;
        s = v + 28'sd32768;
        if (v <= 28'sd0)
        begin
            return 8'd0;
        end
        else if (v >= FULL_SCALE)
        begin
            return 8'd255;
        end
        return s[23:16];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/bbt_stream_if.sv */
`default_nettype none

interface bbt_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bbt_interp.sv */
`default_nettype none

// Two-stage interpolated lookup of log2(1+g) or 2^g, g in Q30 below one.
module bbt_interp import bbt_pkg::*; #(
    parameter int DEPTH  = 64,
    parameter bit IS_EXP = 1'b0
) (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [29:0] g,
    output logic      [31:0] value
);
    localparam int IW = $clog2(DEPTH);
    localparam int TW = $clog2(DEPTH + 1);
    localparam int PW = 30 + IW;

    logic [31:0]   tab [0:DEPTH];
    logic [PW-1:0] pos_next;
    logic [IW-1:0] idx_reg;
    logic [29:0]   w_reg;
    logic [31:0]   lo;
    logic [31:0]   hi;
    logic [61:0]   prod;
    logic [31:0]   value_reg;

    for (genvar i = 0; i <= DEPTH; i++)
    begin : g_tab
        localparam longint unsigned QPOS =
            ((64'(i) << 30) + 64'(DEPTH / 2)) / 64'(DEPTH);
        if (i == DEPTH)
        begin : g_end
            assign tab[i] = IS_EXP ? 32'h8000_0000 : 32'h4000_0000;
        end
        else
        begin : g_mid
            assign tab[i] = bbt_tab_entry(QPOS, IS_EXP);
        end
    end

    assign pos_next = PW'(g) * PW'(DEPTH);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_reg <= pos_next[PW-1:30];
            w_reg   <= pos_next[29:0];
        end
    end

    always_comb
    begin
        lo   = tab[TW'(idx_reg)];
        hi   = tab[TW'(idx_reg) + TW'(1)];
        prod = 62'(hi - lo) * 62'(w_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= lo + prod[61:30];
        end
    end

    assign value = value_reg;
endmodule

`default_nettype wire

/* hw/rtl/bbt_ln.sv */
`default_nettype none

// Natural log of a Q16 value (taken as at least one), Q30 result, four stages.
module bbt_ln import bbt_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [24:0] x,
    output logic      [32:0] ln
);
    logic [24:0] xc;
    logic [4:0]  p;
    logic [31:0] norm;
    logic [29:0] g_reg;
    logic [3:0]  ip_reg [0:2];
    logic [31:0] frac;
    logic [61:0] fprod;
    logic [33:0] ipart;
    logic [31:0] fr;
    logic [32:0] ln_reg;

    always_comb
    begin
        xc = (x < 25'h001_0000) ? 25'h001_0000 : x;
        p  = 5'd16;
        for (int i = 17; i < 25; i++)
        begin
            if (xc[i])
            begin
                p = 5'(i);
            end
        end
        norm = 32'(xc) << (5'd30 - p);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg     <= norm[29:0];
            ip_reg[0] <= 4'(p - 5'd16);
            ip_reg[1] <= ip_reg[0];
            ip_reg[2] <= ip_reg[1];
        end
    end

    bbt_interp #(.DEPTH(DEPTH), .IS_EXP(1'b0)) u_log2 (
        .clk   (clk),
        .en    (en),
        .g     (g_reg),
        .value (frac)
    );

    always_comb
    begin
        fprod = 62'(frac) * 62'(LN2_Q30[29:0]);
        fr    = 32'((fprod + 62'(HALF_Q30)) >> 30);
        ipart = 34'(ip_reg[2]) * 34'(LN2_Q30[29:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ln_reg <= 33'(ipart + 34'(fr));
        end
    end

    assign ln = ln_reg;
endmodule

`default_nettype wire

/* hw/rtl/bbt_pow.sv */
`default_nettype none

// coef * x^-e from ln(x): six stages, the divide by ln2 done by reciprocal.
module bbt_pow import bbt_pkg::*; #(
    parameter int          DEPTH    = 64,
    parameter logic [27:0] EXP_Q30  = 28'd0,
    parameter logic [24:0] COEF_Q16 = 25'd0
) (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [32:0] ln,
    output logic      [24:0] ch
);
    logic [30:0] y_reg;
    logic [30:0] y2_reg;
    logic [31:0] est_reg;
    logic [31:0] z_reg;
    logic [61:0] rem;
    logic [29:0] f;
    logic [29:0] g;
    logic [1:0]  n_reg [0:1];
    logic        fz_reg [0:1];
    logic [31:0] val;
    logic [30:0] pw;
    logic [24:0] ch_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg   <= 31'((62'(EXP_Q30) * 62'(ln) + 62'(HALF_Q30)) >> 30);
            y2_reg  <= y_reg;
            est_reg <= 32'((63'(y_reg) * 63'(RECIP_LN2[30:0])) >> 30);
        end
    end

    // The estimate is low by at most one; the remainder decides.
    assign rem = (62'(y2_reg) << 30) - 62'(est_reg) * 62'(LN2_Q30[29:0]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg <= est_reg + ((rem >= 62'(LN2_Q30[29:0])) ? 32'd1 : 32'd0);
        end
    end

    always_comb
    begin
        f = z_reg[29:0];
        g = 30'(31'h4000_0000 - {1'b0, f});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]  <= z_reg[31:30];
            n_reg[1]  <= n_reg[0];
            fz_reg[0] <= (f == 30'd0);
            fz_reg[1] <= fz_reg[0];
        end
    end

    bbt_interp #(.DEPTH(DEPTH), .IS_EXP(1'b1)) u_exp2 (
        .clk   (clk),
        .en    (en),
        .g     (g),
        .value (val)
    );

    always_comb
    begin
        if (fz_reg[1])
        begin
            pw = 31'h4000_0000 >> n_reg[1];
        end
        else
        begin
            pw = 31'(val >> ({1'b0, n_reg[1]} + 3'd1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ch_reg <= 25'((56'(COEF_Q16) * 56'(pw) + 56'(HALF_Q30)) >> 30);
        end
    end

    assign ch = ch_reg;
endmodule

`default_nettype wire

/* hw/rtl/blackbody_temperature_to_rgb.sv */
// Channel      Dir  Payload                    Meaning
// temperature  in   kelvin[15:0]               color temperature in whole kelvin
// color        out  red[7:0] green[7:0] blue   blackbody color, 255 is full scale
//
// One request is taken every cycle while the skid register is empty. A result
// passes one stage for the divide by 100, four for the log unit, six for the
// power unit and then the output register.
// rst_n clears only the valid bits; data registers carry no reset.
// A stalled output keeps its result and a skid register catches one more; the
// pipeline then freezes as a whole and temperature.ready drops until it drains.
`default_nettype none

module blackbody_temperature_to_rgb import bbt_pkg::*; #(
    parameter int LOG_TABLE_DEPTH = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bbt_stream_if.sink   temperature,
    bbt_stream_if.source color
);
    // Valid and flag stages: the input register, then ln (4) and power (6).
    localparam int NSTAGE = 11;

    logic                    en;
    logic [NSTAGE-1:0]       v_reg;
    bbt_flags_t              fl_reg [0:NSTAGE-1];

    logic [15:0]             kc;
    logic [31:0]             num;
    logic [63:0]             tprod;
    bbt_flags_t              fl_next;
    logic [24:0]             t_reg;

    logic [24:0]             xa;
    logic [24:0]             xb;
    logic [32:0]             ln_a;
    logic [32:0]             ln_b;

    logic [55:0]             gprod;
    logic [56:0]             bprod;
    logic signed [27:0]      glo_reg [0:5];
    logic signed [27:0]      blo_reg [0:5];

    logic [24:0]             red_pow;
    logic [24:0]             green_pow;

    logic signed [27:0]      r_val;
    logic signed [27:0]      g_val;
    logic signed [27:0]      b_val;
    bbt_rgb_t                rgb;
    bbt_flags_t              fl_end;

    logic                    out_valid_reg;
    logic                    skid_valid_reg;
    bbt_rgb_t                out_reg;
    bbt_rgb_t                skid_reg;

    // The pipeline moves unless the skid register is holding a result.
    assign en = !skid_valid_reg;
    assign temperature.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NSTAGE-2:0], temperature.valid};
        end
    end

    // Stage 1: clamp, knee flags and t = k * 655.36 rounded down after +50.
    always_comb
    begin
        kc = temperature.payload.kelvin;
        if (kc < KELVIN_MIN)
        begin
            kc = KELVIN_MIN;
        end
        else if (kc > KELVIN_MAX)
        begin
            kc = KELVIN_MAX;
        end
        num   = {kc, 16'h0000} + 32'd50;
        tprod = 64'(num) * RECIP_100;
        fl_next.red_hi    = (kc <= KELVIN_KNEE);
        fl_next.blue_full = (kc >= KELVIN_KNEE);
        fl_next.blue_zero = (kc <= KELVIN_BLUE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg     <= 25'(tprod >> 38);
            fl_reg[0] <= fl_next;
            for (int i = 1; i < NSTAGE; i++)
            begin
                fl_reg[i] <= fl_reg[i-1];
            end
        end
    end

    // Log unit A sees t at or below the knee (green) and t-60 above it (power).
    // Log unit B always sees t-10 for the blue curve.
    assign xa = fl_reg[0].red_hi ? t_reg : t_reg - T_OFS_60;
    assign xb = t_reg - T_OFS_10;

    bbt_ln #(.DEPTH(LOG_TABLE_DEPTH)) u_ln_a (
        .clk (clk),
        .en  (en),
        .x   (xa),
        .ln  (ln_a)
    );

    bbt_ln #(.DEPTH(LOG_TABLE_DEPTH)) u_ln_b (
        .clk (clk),
        .en  (en),
        .x   (xb),
        .ln  (ln_b)
    );

    // Log-fit lanes: one multiply, then a delay line that matches the power unit.
    assign gprod = 56'(AG1_Q16[22:0]) * 56'(ln_a) + 56'(HALF_Q30);
    assign bprod = 57'(AB_Q16[23:0]) * 57'(ln_b) + 57'(HALF_Q30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            glo_reg[0] <= $signed(28'(gprod >> 30)) - $signed(28'(BG1_Q16));
            blo_reg[0] <= $signed(28'(bprod >> 30)) - $signed(28'(BB_Q16));
            for (int i = 1; i < 6; i++)
            begin
                glo_reg[i] <= glo_reg[i-1];
                blo_reg[i] <= blo_reg[i-1];
            end
        end
    end

    bbt_pow #(
        .DEPTH    (LOG_TABLE_DEPTH),
        .EXP_Q30  (ER_Q30[27:0]),
        .COEF_Q16 (AR_Q16[24:0])
    ) u_pow_red (
        .clk (clk),
        .en  (en),
        .ln  (ln_a),
        .ch  (red_pow)
    );

    bbt_pow #(
        .DEPTH    (LOG_TABLE_DEPTH),
        .EXP_Q30  (EG_Q30[27:0]),
        .COEF_Q16 (AG2_Q16[24:0])
    ) u_pow_green (
        .clk (clk),
        .en  (en),
        .ln  (ln_a),
        .ch  (green_pow)
    );

    // Final selection by the knees and saturation to a byte.
    always_comb
    begin
        fl_end = fl_reg[NSTAGE-1];
        r_val  = fl_end.red_hi ? FULL_SCALE : $signed({3'b000, red_pow});
        g_val  = fl_end.red_hi ? glo_reg[5] : $signed({3'b000, green_pow});
        if (fl_end.blue_full)
        begin
            b_val = FULL_SCALE;
        end
        else if (fl_end.blue_zero)
        begin
            b_val = 28'sd0;
        end
        else
        begin
            b_val = blo_reg[5];
        end
        rgb.red   = bbt_to_byte(r_val);
        rgb.green = bbt_to_byte(g_val);
        rgb.blue  = bbt_to_byte(b_val);
    end

    // Output register with a one-entry skid behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!skid_valid_reg)
        begin
            if (!out_valid_reg || color.ready)
            begin
                out_valid_reg <= v_reg[NSTAGE-1];
            end
            else if (v_reg[NSTAGE-1])
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (color.ready)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            if (!out_valid_reg || color.ready)
            begin
                out_reg <= rgb;
            end
            else
            begin
                skid_reg <= rgb;
            end
        end
        else if (color.ready)
        begin
            out_reg <= skid_reg;
        end
    end

    assign color.valid   = out_valid_reg;
    assign color.payload = out_reg;

`ifndef SYNTHESIS
    // The skid register only ever holds a result behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // The skid register fills only when the output was stalled.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !color.ready))
        else $error("skid register filled without an output stall");

    // Blue cannot be both full and zero for a live item.
    a_blue_knees: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NSTAGE-1] |-> !(fl_reg[NSTAGE-1].blue_full && fl_reg[NSTAGE-1].blue_zero))
        else $error("conflicting blue knee flags");
`endif
endmodule

`default_nettype wire

/* verif/tb_blackbody_temperature_to_rgb.sv */
`default_nettype none

module tb_blackbody_temperature_to_rgb;
    import bbt_pkg::*;

    localparam int TAB_DEPTH = 64;
    localparam int STALL_LIMIT = 20000;
    localparam longint unsigned ONE = 64'd1 << 30;

    logic clk;
    logic rst_n;

    bbt_stream_if #(.payload_t(bbt_kelvin_t)) temperature ();
    bbt_stream_if #(.payload_t(bbt_rgb_t))    color ();

    blackbody_temperature_to_rgb #(.LOG_TABLE_DEPTH(TAB_DEPTH)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .temperature (temperature.sink),
        .color       (color.source)
    );

    // Interpolation tables of log2(1+f) and 2^f, built once at time zero
    // from the bit-serial squaring and square-root chain.
    longint unsigned log2_lut [0:TAB_DEPTH];
    longint unsigned exp2_lut [0:TAB_DEPTH];

    bbt_rgb_t rgb_expected [$];
    int       error_count;
    int       idle_cycles;
    int       send_gap_pct;
    int       sink_gap_pct;
    bit       sink_hold;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic build_luts();
        longint unsigned root [0:30];
        longint unsigned q;
        longint unsigned y;
        longint unsigned res;
        longint unsigned r;
        root[0] = 2 * ONE;
        for (int k = 1; k <= 30; k++)
        begin
            root[k] = int_sqrt(root[k-1] << 30);
        end
        for (int i = 0; i < TAB_DEPTH; i++)
        begin
            q   = ((longint'(i) << 30) + TAB_DEPTH / 2) / TAB_DEPTH;
            y   = ONE + q;
            res = 0;
            r   = ONE;
            for (int b = 1; b <= 30; b++)
            begin
                y = (y * y + HALF_Q30) >> 30;
                if (y >= 2 * ONE)
                begin
                    y   = y >> 1;
                    res = res | (64'd1 << (30 - b));
                end
                if (q[30-b])
                begin
                    r = (r * root[b] + HALF_Q30) >> 30;
                end
            end
            log2_lut[i] = res;
            exp2_lut[i] = r;
        end
        log2_lut[TAB_DEPTH] = ONE;
        exp2_lut[TAB_DEPTH] = 2 * ONE;
    endtask

    function automatic longint unsigned interp(bit use_exp, longint unsigned g);
        longint unsigned pos;
        longint unsigned idx;
        longint unsigned w;
        longint unsigned lo;
        longint unsigned hi;
        pos = g * TAB_DEPTH;
        idx = pos >> 30;
        w   = pos & (ONE - 1);
        if (idx >= TAB_DEPTH)
        begin
            return use_exp ? exp2_lut[TAB_DEPTH] : log2_lut[TAB_DEPTH];
        end
        lo = use_exp ? exp2_lut[idx] : log2_lut[idx];
        hi = use_exp ? exp2_lut[idx+1] : log2_lut[idx+1];
        return lo + (((hi - lo) * w) >> 30);
    endfunction

    // Natural log of a Q16 value of at least one, in Q30.
    function automatic longint unsigned nat_log(longint unsigned x);
        int p;
        longint unsigned y;
        longint unsigned l2;
        p = 16;
        if (x < (64'd1 << 16))
        begin
            x = 64'd1 << 16;
        end
        if (x >= (64'd1 << 32))
        begin
            x = (64'd1 << 32) - 1;
        end
        while (p < 31 && (x >> (p + 1)) != 0)
        begin
            p++;
        end
        y  = (p <= 30) ? (x << (30 - p)) : (x >> (p - 30));
        l2 = (longint'(p - 16) << 30) + interp(1'b0, y - ONE);
        return (l2 * LN2_Q30 + HALF_Q30) >> 30;
    endfunction

    // x raised to minus e, computed as a power of two.
    function automatic longint unsigned inv_power(longint unsigned x, longint unsigned e);
        longint unsigned y;
        longint unsigned z;
        longint unsigned n;
        longint unsigned f;
        y = (e * nat_log(x) + HALF_Q30) >> 30;
        z = (y << 30) / LN2_Q30;
        n = z >> 30;
        f = z & (ONE - 1);
        if (f == 0)
        begin
            return (n >= 62) ? 0 : (ONE >> n);
        end
        if (n + 1 >= 62)
        begin
            return 0;
        end
        return interp(1'b1, ONE - f) >> (n + 1);
    endfunction

    function automatic logic [7:0] sat_byte(longint v);
        if (v <= 0)
        begin
            return 8'd0;
        end
        if (v >= (longint'(255) << 16))
        begin
            return 8'd255;
        end
        return 8'((v + 32768) >> 16);
    endfunction

    function automatic bbt_rgb_t blackbody_color(logic [15:0] kelvin);
        longint unsigned k;
        longint unsigned t;
        longint unsigned x;
        longint r;
        longint g;
        longint b;
        bbt_rgb_t c;
        k = kelvin;
        if (k < 1000)
        begin
            k = 1000;
        end
        if (k > 40000)
        begin
            k = 40000;
        end
        t = ((k << 16) + 50) / 100;
        if (k <= 6600)
        begin
            r = longint'(255) << 16;
            g = longint'((AG1_Q16 * nat_log(t) + HALF_Q30) >> 30) - longint'(BG1_Q16);
        end
        else
        begin
            x = t - (64'd60 << 16);
            r = longint'((AR_Q16 * inv_power(x, ER_Q30) + HALF_Q30) >> 30);
            g = longint'((AG2_Q16 * inv_power(x, EG_Q30) + HALF_Q30) >> 30);
        end
        if (k >= 6600)
        begin
            b = longint'(255) << 16;
        end
        else if (k <= 1900)
        begin
            b = 0;
        end
        else
        begin
            b = longint'((AB_Q16 * nat_log(t - (64'd10 << 16)) + HALF_Q30) >> 30)
                - longint'(BB_Q16);
        end
        c.red   = sat_byte(r);
        c.green = sat_byte(g);
        c.blue  = sat_byte(b);
        return c;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Offers one request after a random gap and waits for it to be taken.
    // Valid stays high after the accepting edge until the next gap or the
    // end of the run, so back-to-back requests need no idle cycle.
    // The expected color is queued at the accepting edge.
    task automatic send_kelvin(logic [15:0] kelvin);
        while ($urandom_range(99) < send_gap_pct)
        begin
            temperature.valid <= 1'b0;
            @(negedge clk);
        end
        temperature.valid   <= 1'b1;
        temperature.payload <= kelvin;
        @(posedge clk);
        while (!temperature.ready)
        begin
            @(posedge clk);
        end
        rgb_expected.push_back(blackbody_color(kelvin));
        @(negedge clk);
    endtask

    // The receiver draws ready at every falling edge; the hold flag forces
    // a long stall so that the pipeline fills and blocks its input.
    always @(negedge clk)
    begin
        if (!rst_n || sink_hold)
        begin
            color.ready <= 1'b0;
        end
        else
        begin
            color.ready <= ($urandom_range(99) >= sink_gap_pct);
        end
    end

    // Checks each accepted color against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && color.valid && color.ready)
        begin
            if (rgb_expected.size() == 0)
            begin
                report_mismatch("unexpected color", int'(color.payload), 0);
            end
            else
            begin
                bbt_rgb_t want;
                want = rgb_expected.pop_front();
                if (color.payload.red !== want.red)
                begin
                    report_mismatch("red", color.payload.red, want.red);
                end
                if (color.payload.green !== want.green)
                begin
                    report_mismatch("green", color.payload.green, want.green);
                end
                if (color.payload.blue !== want.blue)
                begin
                    report_mismatch("blue", color.payload.blue, want.blue);
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge clk)
    begin
        if ((temperature.valid && temperature.ready) || (color.valid && color.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Corners: clamps, both knees and the cases beside them.
    task automatic test_directed();
        logic [15:0] corners [] = '{16'd0, 16'd1, 16'd999, 16'd1000, 16'd1001,
            16'd1899, 16'd1900, 16'd1901, 16'd2000, 16'd4000, 16'd6599, 16'd6600,
            16'd6601, 16'd6700, 16'd10000, 16'd20000, 16'd39999, 16'd40000,
            16'd40001, 16'd65535, 16'hAAAA, 16'h5555};
        foreach (corners[i])
        begin
            send_kelvin(corners[i]);
        end
    endtask

    // Mostly the active 1000..40000 range, with some clamped values.
    task automatic test_random(int count);
        int sel;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(9);
            if (sel < 5)
            begin
                send_kelvin(16'($urandom_range(1000, 8000)));
            end
            else if (sel < 8)
            begin
                send_kelvin(16'($urandom_range(1000, 40000)));
            end
            else
            begin
                send_kelvin(16'($urandom));
            end
        end
    endtask

    // The receiver stalls for a long stretch while requests keep coming.
    task automatic test_backpressure();
        fork
            begin
                sink_hold = 1'b1;
                repeat (60) @(negedge clk);
                sink_hold = 1'b0;
            end
            test_random(40);
        join
    endtask

    initial
    begin
        error_count         = 0;
        sink_hold           = 1'b0;
        send_gap_pct        = 7;
        sink_gap_pct        = 61;
        rst_n               = 1'b0;
        temperature.valid   = 1'b0;
        temperature.payload = '0;
        build_luts();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(500);
        send_gap_pct = 61;
        sink_gap_pct = 7;
        test_random(500);
        send_gap_pct = 0;
        sink_gap_pct = 0;
        test_backpressure();
        test_random(540);
        temperature.valid <= 1'b0;

        while (rgb_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
